>>> hdl/u2a_pkg.sv
// ---------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and helpers for the unsigned-to-ASCII digit core.
// ---------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

    localparam int VALUE_WIDTH = 32;

    // Number of decimal digits needed for the largest VALUE_WIDTH-bit value
    function automatic int dec_digit_count(input int w);
        logic [67:0] lim;
        logic [67:0] pw;
        int          n;
        lim = 68'd1 << w;
        pw  = 68'd10;
        n   = 1;
        for (int i = 0; i < 20; i++)
        begin
            if (pw < lim)
            begin
                n  = n + 1;
                pw = pw * 68'd10;
            end
        end
        return n;
    endfunction

    localparam int DEC_DIGITS = dec_digit_count(VALUE_WIDTH);
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int PAD_WIDTH  = HEX_DIGITS * 4;
    localparam int IDX_W      = $clog2(DEC_DIGITS);
    localparam int HEX_IDX_W  = (HEX_DIGITS > 1) ? $clog2(HEX_DIGITS) : 1;

    // ceil(2^(W+3) / 10): exact divide-by-ten for every W-bit value
    localparam logic [VALUE_WIDTH+3:0] POW2_W3 = {1'b1, {(VALUE_WIDTH + 3){1'b0}}};
    localparam logic [VALUE_WIDTH+3:0] RECIP_WIDE =
        (POW2_W3 + (VALUE_WIDTH + 4)'(9)) / (VALUE_WIDTH + 4)'(10);
    localparam logic [VALUE_WIDTH-1:0] DIV10_RECIP = RECIP_WIDE[VALUE_WIDTH-1:0];

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FMT_DEC   = 2'd0;
    localparam logic [1:0] FMT_LOWER = 2'd1;
    localparam logic [1:0] FMT_UPPER = 2'd2;

    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [1:0]             number_format;
    } in_t;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last_digit;
    } out_t;

    // Classified item as held in the queue
    typedef struct packed {
        logic [PAD_WIDTH-1:0] value;
        logic                 is_dec;
        logic                 upper;
        logic [HEX_IDX_W-1:0] hex_top;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic pop;
        logic busy;
    } back_ctl_t;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (d < 4'd10)
        begin
            return ASCII_ZERO + {3'b000, d};
        end
        return base + {3'b000, d} - 7'd10;
    endfunction

endpackage

`default_nettype wire

>>> hdl/u2a_front.sv
// ---------------------------------------------------------------------------
// u2a_front
// Accepts items, decodes the format code and locates the top hex digit.
// ---------------------------------------------------------------------------
`default_nettype none

module u2a_front (
    input  wire  u2a_pkg::in_t      item,
    input  wire  u2a_pkg::q_status_t q_stat,
    input  wire                     item_valid,
    output logic                    item_ready,
    output logic                    push,
    output u2a_pkg::job_t           job
);

    logic [u2a_pkg::PAD_WIDTH-1:0] padded;
    logic [u2a_pkg::HEX_IDX_W-1:0] top;

    assign item_ready = !q_stat.full;
    assign push       = item_valid && !q_stat.full;
    assign padded     = u2a_pkg::PAD_WIDTH'(item.value);

    // Highest nonzero nibble; zero value keeps index 0
    always_comb
    begin
        top = '0;
        for (int i = 0; i < u2a_pkg::HEX_DIGITS; i++)
        begin
            if (padded[i*4 +: 4] != 4'd0)
            begin
                top = u2a_pkg::HEX_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        job.value   = padded;
        job.is_dec  = (item.number_format == u2a_pkg::FMT_DEC);
        job.upper   = (item.number_format != u2a_pkg::FMT_LOWER);
        job.hex_top = top;
    end

endmodule

`default_nettype wire

>>> hdl/u2a_queue.sv
// ---------------------------------------------------------------------------
// u2a_queue
// Two-entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module u2a_queue (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  wire  u2a_pkg::job_t     push_job,
    input  wire  u2a_pkg::back_ctl_t back_ctl,
    output u2a_pkg::job_t           head,
    output u2a_pkg::q_status_t      q_stat
);

    u2a_pkg::job_t                 mem [u2a_pkg::QUEUE_DEPTH];
    logic [u2a_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [u2a_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [u2a_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign q_stat.full  = (count_reg == u2a_pkg::QCNT_W'(u2a_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == u2a_pkg::QPTR_W'(u2a_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (back_ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == u2a_pkg::QPTR_W'(u2a_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, back_ctl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> hdl/u2a_back.sv
// ---------------------------------------------------------------------------
// u2a_back
// Expands one queued item into ASCII digits through a registered output slot.
// ---------------------------------------------------------------------------
`default_nettype none

module u2a_back (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire  u2a_pkg::job_t     head,
    input  wire  u2a_pkg::q_status_t q_stat,
    output u2a_pkg::back_ctl_t      back_ctl,
    output logic                    digit_valid,
    input  wire                     digit_ready,
    output u2a_pkg::out_t           digit
);

    localparam int W = u2a_pkg::VALUE_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [u2a_pkg::PAD_WIDTH-1:0] val_reg, val_next;
    logic [u2a_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                          is_dec_reg, is_dec_next;
    logic                          upper_reg, upper_next;
    logic                          out_valid_reg, out_valid_next;
    u2a_pkg::out_t                 out_reg, out_next;
    logic [3:0]                    dbuf [u2a_pkg::DEC_DIGITS];
    logic                          dbuf_we;

    logic [W-1:0]                  v_lo;
    logic [2*W-1:0]                prod;
    logic [W-1:0]                  quot;
    logic [W-1:0]                  q_x10;
    logic [3:0]                    rem;
    logic [3:0]                    nib [u2a_pkg::HEX_DIGITS];
    logic [3:0]                    cur_digit;
    logic                          slot_free;

    // Divide by ten via reciprocal multiply; remainder from q*10
    assign v_lo  = val_reg[W-1:0];
    assign prod  = v_lo * u2a_pkg::DIV10_RECIP;
    assign quot  = W'(prod[2*W-1:W+3]);
    assign q_x10 = (quot << 3) + (quot << 1);
    assign rem   = 4'(v_lo - q_x10);

    always_comb
    begin
        for (int i = 0; i < u2a_pkg::HEX_DIGITS; i++)
        begin
            nib[i] = val_reg[i*4 +: 4];
        end
    end

    assign cur_digit = is_dec_reg ? dbuf[idx_reg] : nib[idx_reg[u2a_pkg::HEX_IDX_W-1:0]];
    assign slot_free = !out_valid_reg || digit_ready;

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        is_dec_next    = is_dec_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg && !digit_ready;
        out_next       = out_reg;
        dbuf_we        = 1'b0;
        back_ctl.pop   = 1'b0;
        back_ctl.busy  = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    back_ctl.pop = 1'b1;
                    val_next     = head.value;
                    is_dec_next  = head.is_dec;
                    upper_next   = head.upper;
                    if (head.is_dec)
                    begin
                        idx_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        idx_next   = u2a_pkg::IDX_W'(head.hex_top);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV:
            begin
                // Store digits least significant first; stop when quotient hits zero
                dbuf_we  = 1'b1;
                val_next = u2a_pkg::PAD_WIDTH'(quot);
                if (quot == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.digit_char = u2a_pkg::digit_to_ascii(cur_digit, upper_reg);
                    out_next.last_digit = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        is_dec_reg <= is_dec_next;
        upper_reg  <= upper_next;
        out_reg    <= out_next;
        if (dbuf_we)
        begin
            dbuf[idx_reg] <= rem;
        end
    end

    assign digit_valid = out_valid_reg;
    assign digit       = out_reg;

endmodule

`default_nettype wire

>>> hdl/unsigned_to_ascii_digits_core.sv
// ---------------------------------------------------------------------------
// unsigned_to_ascii_digits_core
// Unsigned number to ASCII decimal / hex digits, most significant first.
// ---------------------------------------------------------------------------
// Usage:
//   item channel : item_valid/item_ready, payload item (value, number_format).
//                  Format 0 is decimal, 1 lowercase hex, anything else uppercase hex.
//   digit channel: digit_valid/digit_ready, one beat per digit with digit_char
//                  and last_digit set on the final digit of the number.
//   Items enter a two-entry queue, so up to two are taken while the back end
//   is still busy. A hex item is popped from the queue, then emitted at one
//   digit per cycle while the output slot is free.
//   A decimal item is popped, then the divide-by-ten unit (one reciprocal
//   multiply) writes one digit per cycle into a digit buffer, then the buffer
//   is read out one digit per cycle while the output slot is free.
//   The first digit becomes valid when the emit state loads the output register,
//   after the pop (hex) or after the divide steps (decimal).
//   When digit_ready is low the output register holds its beat and the emit
//   state waits; the queue keeps accepting until full, then item_ready drops.
//   Reset empties the queue and the output register and returns the back end to idle.
// ---------------------------------------------------------------------------
`default_nettype none

module unsigned_to_ascii_digits_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_ready,
    input  wire  u2a_pkg::in_t  item,
    output logic                digit_valid,
    input  wire                 digit_ready,
    output u2a_pkg::out_t       digit
);

    u2a_pkg::job_t      new_job;
    u2a_pkg::job_t      head;
    u2a_pkg::q_status_t q_stat;
    u2a_pkg::back_ctl_t back_ctl;
    logic               push;

    u2a_front u_front (
        .item       (item),
        .q_stat     (q_stat),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .push       (push),
        .job        (new_job)
    );

    u2a_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (new_job),
        .back_ctl (back_ctl),
        .head     (head),
        .q_stat   (q_stat)
    );

    u2a_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .back_ctl    (back_ctl),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit       (digit)
    );

`ifndef NO_ASSERTIONS
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        back_ctl.pop |-> (!back_ctl.busy && !q_stat.empty))
        else $error("queue popped while back end busy or queue empty");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> ((digit.digit_char >= 7'h30 && digit.digit_char <= 7'h39) ||
                         (digit.digit_char >= 7'h41 && digit.digit_char <= 7'h46) ||
                         (digit.digit_char >= 7'h61 && digit.digit_char <= 7'h66)))
        else $error("digit character outside decimal or hex range");

    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        back_ctl.pop |=> back_ctl.busy)
        else $error("back end did not start after pop");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives numbers with format codes into unsigned_to_ascii_digits_core and
// checks every digit beat against a predictor that spells each accepted
// number in decimal or hex, most significant digit first. Random bursts of
// idle cycles on the item side and of stalls on the digit side cover every
// phase of the core's work. The final stretch of the run has no idling.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Code 3 has no name in the package; the core spells it as uppercase hex.
    localparam logic [1:0] FMT_SPARE_UPPER = 2'd3;

    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;

    localparam int RANDOM_ITEMS = 470;
    localparam int CALM_TAIL    = 60;
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic          item_valid = 1'b0;
    logic          item_ready;
    u2a_pkg::in_t  item = '0;
    logic          digit_valid;
    logic          digit_ready = 1'b0;
    u2a_pkg::out_t digit;

    u2a_pkg::in_t  pending_items[$];
    u2a_pkg::out_t expected_digits[$];

    logic          item_fire = 1'b0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            fail_count = 0;
    u2a_pkg::out_t want_digit;

    unsigned_to_ascii_digits_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit       (digit)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Spell one number into the queue of expected digit beats.
    function automatic void spell_number(input u2a_pkg::in_t num_item);
        logic [u2a_pkg::VALUE_WIDTH-1:0] rest;
        logic [u2a_pkg::VALUE_WIDTH-1:0] radix;
        logic [3:0]                      digs[0:23];
        logic                            upper;
        int                              n;
        u2a_pkg::out_t                   beat;
        rest  = num_item.value;
        radix = (num_item.number_format == u2a_pkg::FMT_DEC) ? 10 : 16;
        upper = (num_item.number_format == u2a_pkg::FMT_UPPER)
                || (num_item.number_format == FMT_SPARE_UPPER);
        n = 0;
        do
        begin
            digs[n] = 4'(rest % radix);
            rest    = rest / radix;
            n++;
        end
        while (rest != 0);
        for (int k = n - 1; k >= 0; k--)
        begin
            if (digs[k] < 4'd10)
                beat.digit_char = CHAR_ZERO + 7'(digs[k]);
            else if (upper)
                beat.digit_char = CHAR_UPPER_A + 7'(digs[k]) - 7'd10;
            else
                beat.digit_char = CHAR_LOWER_A + 7'(digs[k]) - 7'd10;
            beat.last_digit = (k == 0);
            expected_digits.push_back(beat);
        end
    endfunction

    function automatic void add_number(input logic [u2a_pkg::VALUE_WIDTH-1:0] v,
                                       input logic [1:0] fmt);
        u2a_pkg::in_t it;
        it.value         = v;
        it.number_format = fmt;
        pending_items.push_back(it);
    endfunction

    // Item side: hold each beat until taken, idle in random bursts.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap   <= send_gap - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
                if (pending_items.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 10);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Digit side: stall in random bursts until the calm tail.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left  <= stall_left - 1;
                digit_ready <= 1'b0;
            end
            else
            begin
                digit_ready <= 1'b1;
                if (pending_items.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                    stall_left <= $urandom_range(1, 10);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_fire <= item_valid && item_ready;
            if (item_valid && item_ready)
                spell_number(item);
            if (digit_valid && digit_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    $error("unexpected digit beat: digit_char %0d last_digit %0b",
                           digit.digit_char, digit.last_digit);
                    fail_count++;
                end
                else
                begin
                    want_digit = expected_digits.pop_front();
                    if (digit.digit_char !== want_digit.digit_char)
                    begin
                        $error("digit_char: expected %0d, got %0d",
                               want_digit.digit_char, digit.digit_char);
                        fail_count++;
                    end
                    if (digit.last_digit !== want_digit.last_digit)
                    begin
                        $error("last_digit: expected %0b, got %0b",
                               want_digit.last_digit, digit.last_digit);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin : run_numbers
        logic [1:0]                      fmt;
        logic [u2a_pkg::VALUE_WIDTH-1:0] v;
        longint unsigned                 p10;
        int                              p;

        // Zero and the all-ones value in every format code
        for (int f = 0; f < 4; f++)
        begin
            add_number('0, 2'(f));
            add_number('1, 2'(f));
        end
        add_number(1, u2a_pkg::FMT_DEC);
        add_number(9, u2a_pkg::FMT_DEC);
        add_number(10, u2a_pkg::FMT_DEC);
        add_number(999_999_999, u2a_pkg::FMT_DEC);
        add_number(1_000_000_000, u2a_pkg::FMT_DEC);
        add_number(15, u2a_pkg::FMT_LOWER);
        add_number(16, u2a_pkg::FMT_UPPER);
        add_number(32'h0FFF_FFFF, u2a_pkg::FMT_LOWER);
        add_number(32'h1000_0000, u2a_pkg::FMT_UPPER);
        add_number(32'h8000_0000, u2a_pkg::FMT_DEC);
        add_number(32'hABCD_EF01, u2a_pkg::FMT_LOWER);
        add_number(32'hABCD_EF01, u2a_pkg::FMT_UPPER);
        add_number(32'h5555_5555, FMT_SPARE_UPPER);
        add_number(32'hAAAA_AAAA, u2a_pkg::FMT_DEC);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            fmt = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: v = $urandom;
                1: v = $urandom_range(0, 255);
                2:
                begin
                    // land around a change in decimal digit count
                    p   = $urandom_range(1, 9);
                    p10 = 1;
                    for (int j = 0; j < p; j++)
                        p10 = p10 * 10;
                    v = u2a_pkg::VALUE_WIDTH'(p10 + $urandom_range(0, 2) - 1);
                end
                3: v = (32'd1 << (4 * $urandom_range(1, 7))) - 1 + $urandom_range(0, 1);
                default: v = $urandom >> $urandom_range(0, 31);
            endcase
            add_number(v, fmt);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
